/* rtl/b64d_pkg.sv */
// Shared constants and the character classifier for the base64 stream decoder.
`default_nettype none

package b64d_pkg;

  localparam int CountWidthDef = 32;
  localparam int TotalWidth    = 32;

  // Classifier codes; SymSkip and SymPad lie above the 6-bit alphabet range
  localparam logic [6:0] SymSkip = 7'd64;
  localparam logic [6:0] SymPad  = 7'd65;
  localparam logic [6:0] SymPlus  = 7'd62;
  localparam logic [6:0] SymSlash = 7'd63;

  localparam logic [1:0] PadMax = 2'd2;

  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [6:0] sym;
    sym = SymSkip;
    if (c >= 8'h41 && c <= 8'h5a) begin
      sym = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      sym = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      sym = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      sym = SymPlus;
    end else if (c == 8'h2f) begin
      sym = SymSlash;
    end else if (c == 8'h3d) begin
      sym = SymPad;
    end
    return sym;
  endfunction

endpackage

`default_nettype wire

/* rtl/base64_stream_decoder.sv */
// Streaming base64 decoder: one text character in, one result word out per character.
//
// Input channel: in_valid / in_stall carry character and final_char. A word is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry data_byte, byte_valid,
// message_end, status and total_bytes, one result word per input word.
// byte_valid marks a completed decoded byte. On the word for the last
// character, message_end is high, status gives 0 for a well-formed message and
// 1 otherwise, and total_bytes gives the decoded byte count (saturating).
// The result word is loaded into the output register at the edge that takes
// the character. Throughput is one character per clock while out_stall does not
// hold the output word; the only path is classify, byte assembly and a counter
// increment into the output register.
// While the output word is held by out_stall, in_stall is high; the decoder
// takes a new word in the same cycle the held one is taken.
// Reset clears all decode state and drops any pending output word. Decode
// state also clears after each final character.
`default_nettype none

module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64d_pkg::CountWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  character,
  input  wire logic        final_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       data_byte,
  output logic             byte_valid,
  output logic             message_end,
  output logic             status,
  output logic [b64d_pkg::TotalWidth-1:0] total_bytes
);

  import b64d_pkg::*;

  logic [5:0]             previous_sextet, previous_sextet_next;
  logic [1:0]             group_position, group_position_next;
  logic [1:0]             pad_count, pad_count_next;
  logic                   two_values_seen, two_values_seen_next;
  logic                   error_seen, error_seen_next;
  logic [COUNT_WIDTH-1:0] byte_total, byte_total_next;

  logic                   in_accept;
  logic [6:0]             sym;
  logic                   is_value;
  logic [7:0]             byte_next;
  logic                   valid_next;
  logic                   bad;
  logic [TotalWidth-1:0]  total_sat;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign sym       = classify(character);
  assign is_value  = (sym < SymSkip);

  always_comb begin
    previous_sextet_next = previous_sextet;
    group_position_next  = group_position;
    pad_count_next       = pad_count;
    two_values_seen_next = two_values_seen;
    error_seen_next      = error_seen;
    byte_total_next      = byte_total;
    byte_next            = 8'd0;
    valid_next           = 1'b0;

    if (sym == SymPad) begin
      if (pad_count >= PadMax) begin
        error_seen_next = 1'b1;
      end else begin
        pad_count_next = pad_count + 2'd1;
      end
    end else if (is_value) begin
      if (pad_count != 2'd0) begin
        error_seen_next = 1'b1;
      end
      case (group_position)
        2'd1: begin
          byte_next  = {previous_sextet, sym[5:4]};
          valid_next = 1'b1;
        end
        2'd2: begin
          byte_next  = {previous_sextet[3:0], sym[5:2]};
          valid_next = 1'b1;
        end
        2'd3: begin
          byte_next  = {previous_sextet[1:0], sym[5:0]};
          valid_next = 1'b1;
        end
        default: begin
          byte_next  = 8'd0;
          valid_next = 1'b0;
        end
      endcase
      if (group_position != 2'd0) begin
        two_values_seen_next = 1'b1;
      end
      previous_sextet_next = sym[5:0];
      group_position_next  = group_position + 2'd1;
      if (valid_next && (byte_total != {COUNT_WIDTH{1'b1}})) begin
        byte_total_next = byte_total + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      end
    end

    // End checks on the updated state
    bad = error_seen_next || !two_values_seen_next;
    case (group_position_next)
      2'd0:    bad = bad || (pad_count_next != 2'd0);
      2'd1:    bad = 1'b1;
      2'd2:    bad = bad || (pad_count_next == 2'd1);
      default: bad = bad || (pad_count_next == 2'd2);
    endcase
  end

  generate
    if (COUNT_WIDTH > TotalWidth) begin : g_sat
      assign total_sat = (|byte_total_next[COUNT_WIDTH-1:TotalWidth]) ?
                         {TotalWidth{1'b1}} : byte_total_next[TotalWidth-1:0];
    end else begin : g_ext
      assign total_sat = TotalWidth'(byte_total_next);
    end
  endgenerate

  // Decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sextet <= '0;
      group_position  <= '0;
      pad_count       <= '0;
      two_values_seen <= 1'b0;
      error_seen      <= 1'b0;
      byte_total      <= '0;
    end else if (in_accept) begin
      if (final_char) begin
        previous_sextet <= '0;
        group_position  <= '0;
        pad_count       <= '0;
        two_values_seen <= 1'b0;
        error_seen      <= 1'b0;
        byte_total      <= '0;
      end else begin
        previous_sextet <= previous_sextet_next;
        group_position  <= group_position_next;
        pad_count       <= pad_count_next;
        two_values_seen <= two_values_seen_next;
        error_seen      <= error_seen_next;
        byte_total      <= byte_total_next;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_byte   <= byte_next;
      byte_valid  <= valid_next;
      message_end <= final_char;
      status      <= final_char && bad;
      total_bytes <= final_char ? total_sat : {TotalWidth{1'b0}};
    end
  end

  // Decode state is back at reset after a final character
  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    in_accept && final_char |=>
      group_position == 2'd0 && pad_count == 2'd0 && !error_seen &&
      !two_values_seen && byte_total == '0)
    else $error("decode state not cleared after final character");

  // Pad count saturates at two
  a_pad_sat: assert property (@(posedge clk) disable iff (rst)
    pad_count != 2'd3)
    else $error("pad count overflow");

  // Status and total only appear on the message end word
  a_end_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !message_end |-> !status && total_bytes == '0)
    else $error("status or total outside message end");

  // First value of a group never completes a byte
  a_group_start: assert property (@(posedge clk) disable iff (rst)
    in_accept && group_position == 2'd0 |=> out_valid && !byte_valid)
    else $error("byte emitted at group start");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the streaming base64 decoder.
`timescale 1ns / 100ps

module tb_top;

  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic                  byte_valid;
    logic                  message_end;
    logic                  status;
    logic [TotalWidth-1:0] total_bytes;
  } result_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_t;

  localparam int QuietLimit = 4000;
  localparam int BurstCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            character = 8'h00;
  logic                  final_char = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            data_byte;
  logic                  byte_valid;
  logic                  message_end;
  logic                  status;
  logic [TotalWidth-1:0] total_bytes;

  base64_stream_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .character  (character),
    .final_char (final_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .message_end(message_end),
    .status     (status),
    .total_bytes(total_bytes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  char_t   char_q[$];
  result_t decoded_q[$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit sender_hold  = 1'b0;
  bit burst_req    = 1'b0;
  bit burst_ack    = 1'b0;
  int burst_left   = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  // decoder state as predicted
  logic [5:0]            prev_sextet = '0;
  logic [1:0]            group_pos   = '0;
  logic [1:0]            pad_cnt     = '0;
  logic                  two_vals    = 1'b0;
  logic                  err_sticky  = 1'b0;
  logic [TotalWidth-1:0] byte_cnt    = '0;

  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
    if (ch >= "a" && ch <= "z") return 7'(ch - "a" + 26);
    if (ch >= "0" && ch <= "9") return 7'(ch - "0" + 52);
    if (ch == "+") return SymPlus;
    if (ch == "/") return SymSlash;
    if (ch == "=") return SymPad;
    return SymSkip;
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  function automatic result_t decode_char(input logic [7:0] ch, input logic last);
    result_t    r;
    logic [6:0] sym;
    logic       bad;
    r = '0;
    sym = sextet_of(ch);
    if (sym == SymPad) begin
      if (pad_cnt == PadMax) err_sticky = 1'b1;
      else pad_cnt = pad_cnt + 2'd1;
    end else if (sym < SymSkip) begin
      // a value after padding still decodes, but poisons the message
      if (pad_cnt != 0) err_sticky = 1'b1;
      case (group_pos)
        2'd1: r.data_byte = {prev_sextet, sym[5:4]};
        2'd2: r.data_byte = {prev_sextet[3:0], sym[5:2]};
        2'd3: r.data_byte = {prev_sextet[1:0], sym[5:0]};
        default: r.data_byte = 8'h00;
      endcase
      r.byte_valid = (group_pos != 0);
      if (group_pos != 0) two_vals = 1'b1;
      prev_sextet = sym[5:0];
      group_pos = group_pos + 2'd1;
      if (r.byte_valid && byte_cnt != '1) byte_cnt = byte_cnt + 1'b1;
    end
    if (last) begin
      bad = err_sticky || !two_vals;
      case (group_pos)
        2'd0: if (pad_cnt != 0) bad = 1'b1;
        2'd1: bad = 1'b1;
        2'd2: if (pad_cnt == 2'd1) bad = 1'b1;
        default: if (pad_cnt == PadMax) bad = 1'b1;
      endcase
      r.message_end = 1'b1;
      r.status = bad;
      r.total_bytes = byte_cnt;
      prev_sextet = '0;
      group_pos = '0;
      pad_cnt = '0;
      two_vals = 1'b0;
      err_sticky = 1'b0;
      byte_cnt = '0;
    end
    return r;
  endfunction

  // driver: offer the next word once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decoded_q.push_back(decode_char(character, final_char));
      if (!in_valid || !in_stall) begin
        if (char_q.size() != 0 && !sender_hold && $urandom_range(0, 99) >= tx_idle_pct) begin
          character  <= char_q[0].ch;
          final_char <= char_q[0].last;
          in_valid   <= 1'b1;
          void'(char_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each taken result word, then pick the next stall
  always @(posedge clk) begin : mon
    result_t got;
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {data_byte, byte_valid, message_end, status, total_bytes};
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: byte %h valid %b end %b status %b total %0d",
                     data_byte, byte_valid, message_end, status, total_bytes);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch (exp/got): byte %h/%h valid %b/%b end %b/%b",
                        " status %b/%b total %0d/%0d"},
                       want.data_byte, got.data_byte, want.byte_valid, got.byte_valid,
                       want.message_end, got.message_end, want.status, got.status,
                       want.total_bytes, got.total_bytes);
          end
        end
      end
      if (burst_left != 0) begin
        out_stall  <= 1'b1;
        burst_left <= burst_left - 1;
      end else if (burst_ack != burst_req) begin
        out_stall  <= 1'b1;
        burst_ack  <= burst_req;
        burst_left <= BurstCycles;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic void push_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) char_q.push_back('{s[i], ends && i == s.len() - 1});
  endfunction

  function automatic logic [7:0] skip_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (sextet_of(c) != SymSkip) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // build one message (well-formed or damaged) and queue it; returns its length
  function automatic int push_message();
    logic [7:0]  msg[$];
    logic [23:0] grp;
    int          n;
    int          rem;
    bit          use_pad;
    int          mode;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
    use_pad = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i += 3) begin
      rem = n - i;
      grp = {8'($urandom), (rem > 1) ? 8'($urandom) : 8'h00, (rem > 2) ? 8'($urandom) : 8'h00};
      msg.push_back(char_of(grp[23:18]));
      msg.push_back(char_of(grp[17:12]));
      if (rem > 1) msg.push_back(char_of(grp[11:6]));
      else if (use_pad) msg.push_back("=");
      if (rem > 2) msg.push_back(char_of(grp[5:0]));
      else if (use_pad) msg.push_back("=");
    end
    mode = ($urandom_range(0, 99) < 75) ? 0 : $urandom_range(1, 6);
    case (mode)
      1: begin
        msg.delete();
        repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
      end
      2: msg.delete($urandom_range(0, msg.size() - 1));
      3: msg.insert($urandom_range(0, msg.size()), "=");
      4: begin
        msg.push_back("=");
        msg.push_back(char_of(6'($urandom)));
      end
      5: repeat ($urandom_range(1, 3)) msg.push_back("=");
      6: begin
        msg.delete();
        msg.push_back(char_of(6'($urandom)));
      end
      default: ;
    endcase
    // scatter skipped characters through the text
    for (int i = msg.size(); i >= 0; i--)
      if ($urandom_range(0, 99) < 8) msg.insert(i, skip_char());
    if (msg.size() == 0) msg.push_back(skip_char());
    foreach (msg[i]) char_q.push_back('{msg[i], i == msg.size() - 1});
    return msg.size();
  endfunction

  function automatic void queue_messages(input int count);
    int added;
    added = 0;
    while (added < count) added += push_message();
  endfunction

  task automatic wait_sent();
    while (char_q.size() != 0 || in_valid) @(negedge clk);
  endtask

  task automatic run_phase(input int tx, input int rx, input int count);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    queue_messages(count);
    wait_sent();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_text("QQ==", 1'b1);
    char_q.push_back('{8'h00, 1'b0});
    push_text("+/z9", 1'b0);
    char_q.push_back('{8'hff, 1'b1});
    push_text("A", 1'b1);
    push_text("Ab=Z", 1'b1);
    push_text("Ab===", 1'b1);
    push_text("ABCDE", 1'b1);
    wait_sent();

    run_phase(0, 0, 450);

    // receiver holds off while the sender keeps streaming
    queue_messages(150);
    burst_req = ~burst_req;
    wait_sent();

    // sender idles, and pauses midway until every result is back
    tx_idle_pct = 70;
    rx_stall_pct = 0;
    queue_messages(450);
    while (char_q.size() > 225) @(negedge clk);
    sender_hold = 1'b1;
    while (in_valid || decoded_q.size() != 0) @(negedge clk);
    sender_hold = 1'b0;
    wait_sent();

    run_phase(0, 70, 400);
    run_phase(34, 34, 400);

    while (decoded_q.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/b64d_pkg.sv
rtl/base64_stream_decoder.sv
bench/tb_top.sv
